FILE: rtl/u8icc_pkg.sv
// Shared types and constants of the UTF-8 identifier character classifier.
`default_nettype none

package u8icc_pkg;

   localparam int DEF_TABLE_DEPTH = 1024;

   localparam int BYTE_W  = 8;
   localparam int ENTRY_W = 10;
   localparam int CP_W    = 21;
   localparam int COUNT_W = 3;

   localparam logic [CP_W-1:0] END_MARK = 21'h11FFFF;

   // Command codes carried on the request tuser.
   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   // Table select codes.
   localparam logic SEL_START    = 1'b0;
   localparam logic SEL_CONTINUE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } u8icc_state_type;

   typedef struct packed {
      logic               en;
      logic [ENTRY_W-1:0] index;
      logic [CP_W-1:0]    first;
      logic [CP_W-1:0]    last;
   } rtab_wr_type;

   typedef struct packed {
      logic done;
      logic hit;
   } rtab_res_type;

endpackage

`default_nettype wire

FILE: rtl/u8icc_range_search.sv
// One range table in memory and its sequential membership search.
`default_nettype none

module u8icc_range_search
   import u8icc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  rtab_wr_type     wr,
   input  logic            start,
   input  logic [CP_W-1:0] cp,
   output rtab_res_type    res
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [2*CP_W-1:0] mem [TABLE_DEPTH];
   logic [2*CP_W-1:0] rd_data_ff;

   logic            busy_ff, busy_in;
   logic            vld_ff, vld_in;
   logic            last_ff, last_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CP_W-1:0] cp_ff;

   logic            rd_en;
   logic            wr_ok;
   logic [CP_W-1:0] ent_first;
   logic [CP_W-1:0] ent_last;
   logic            is_end;
   logic            is_hit;

   assign rd_en     = busy_ff && (cnt_ff < CW'(TABLE_DEPTH));
   assign wr_ok     = wr.en && (32'(wr.index) < TABLE_DEPTH);
   assign ent_first = rd_data_ff[CP_W-1:0];
   assign ent_last  = rd_data_ff[2*CP_W-1:CP_W];
   assign is_end    = (ent_first == END_MARK);
   assign is_hit    = (ent_first <= cp_ff) && (cp_ff <= ent_last);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[AW'(wr.index)] <= {wr.last, wr.first};
      end
      if (rd_en) begin
         rd_data_ff <= mem[cnt_ff[AW-1:0]];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      vld_in   = 1'b0;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      res.done = 1'b0;
      res.hit  = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (rd_en) begin
            cnt_in  = CW'(cnt_ff + 1'b1);
            vld_in  = 1'b1;
            last_in = (cnt_ff == CW'(TABLE_DEPTH - 1));
         end
         // The end marker is checked ahead of the range compare.
         if (vld_ff) begin
            priority if (is_end) begin
               res.done = 1'b1;
            end else if (is_hit) begin
               res.done = 1'b1;
               res.hit  = 1'b1;
            end else if (last_ff) begin
               res.done = 1'b1;
            end
         end
         if (res.done) begin
            busy_in = 1'b0;
            vld_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
         last_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
         last_ff <= last_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cp_ff <= cp;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/utf8_identifier_char_classifier_core.sv
// Top level of the UTF-8 decoder with identifier range table classification.
//
//   Channel   Direction  Handshake               Contents
//   req_      in         req_tvalid/req_tready   data byte or range table write
//   rsp_      out        rsp_tvalid/rsp_tready   codepoint, length, class flags
//
// A table write or a byte that does not end a codepoint leaves the block idle
// and ready for the next beat. A byte that ends a valid codepoint starts both
// table searches in parallel; each reads one entry per cycle from its memory
// port, and the block stays busy until both end and the result is loaded into
// the output register. The longer search examines at most TABLE_DEPTH entries.
// A bad lead byte is answered without a search.
// Reset clears the decode state and all handshake state; the tables are not
// cleared and must be loaded before use. A result waiting on rsp_tready does
// not block new beats until a further result is ready to be presented.
`default_nettype none

module utf8_identifier_char_classifier_core
   import u8icc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: data_byte[7:0], entry_index[17:8], range_first[38:18],
   // range_last[59:39], zero fill [63:60].
   input  logic [63:0] req_tdata,
   // tuser: command[0], table_select[1].
   input  logic [1:0]  req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: codepoint[20:0], byte_count[23:21], is_ident_start[24],
   // is_ident_continue[25], zero fill [31:26].
   output logic [31:0] rsp_tdata,
   // tuser: bad_lead[0].
   output logic        rsp_tuser
);

   // Request fields.
   logic                req_accept;
   logic                req_command;
   logic                req_table_select;
   logic [BYTE_W-1:0]   req_data_byte;
   logic [ENTRY_W-1:0]  req_entry_index;
   logic [CP_W-1:0]     req_range_first;
   logic [CP_W-1:0]     req_range_last;

   assign req_command      = req_tuser[0];
   assign req_table_select = req_tuser[1];
   assign req_data_byte    = req_tdata[7:0];
   assign req_entry_index  = req_tdata[17:8];
   assign req_range_first  = req_tdata[38:18];
   assign req_range_last   = req_tdata[59:39];

   // Controller and decode state.
   u8icc_state_type  state_ff, state_in;
   logic [1:0]       bytes_left_ff, bytes_left_in;
   logic [COUNT_W-1:0] seq_len_ff, seq_len_in;
   logic [CP_W-1:0]  partial_ff, partial_in;

   // Pending result, held while the searches run.
   logic [CP_W-1:0]    pend_cp_ff, pend_cp_in;
   logic [COUNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic               pend_bad_ff, pend_bad_in;
   logic [1:0]         done_ff, done_in;
   logic [1:0]         hit_ff, hit_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]    rsp_cp_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;
   logic               rsp_start_ff;
   logic               rsp_cont_ff;
   logic               rsp_bad_ff;
   logic               rsp_load;

   // Search units.
   logic         search_start;
   rtab_wr_type  wr_start, wr_cont;
   rtab_res_type res_start, res_cont;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // A table write goes straight to the memory selected by tuser.
   always_comb begin
      wr_start.en    = req_accept && (req_command == CMD_WRITE)
                       && (req_table_select == SEL_START);
      wr_start.index = req_entry_index;
      wr_start.first = req_range_first;
      wr_start.last  = req_range_last;
      wr_cont        = wr_start;
      wr_cont.en     = req_accept && (req_command == CMD_WRITE)
                       && (req_table_select == SEL_CONTINUE);
   end

   u8icc_range_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_search_start (
      .clock (clock),
      .reset (reset),
      .wr    (wr_start),
      .start (search_start),
      .cp    (pend_cp_in),
      .res   (res_start)
   );

   u8icc_range_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_search_cont (
      .clock (clock),
      .reset (reset),
      .wr    (wr_cont),
      .start (search_start),
      .cp    (pend_cp_in),
      .res   (res_cont)
   );

   // The output register is free when empty or when its beat leaves now.
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      bytes_left_in = bytes_left_ff;
      seq_len_in    = seq_len_ff;
      partial_in    = partial_ff;
      pend_cp_in    = pend_cp_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_bad_in   = pend_bad_ff;
      done_in       = done_ff | {res_cont.done, res_start.done};
      hit_in        = hit_ff | {res_cont.hit, res_start.hit};
      search_start  = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_command == CMD_DECODE)) begin
               if (bytes_left_ff != 2'd0) begin
                  // Continuation bytes are taken as they come, unchecked.
                  partial_in    = {partial_ff[CP_W-7:0], req_data_byte[5:0]};
                  bytes_left_in = bytes_left_ff - 2'd1;
                  if (bytes_left_ff == 2'd1) begin
                     pend_cp_in   = partial_in;
                     pend_cnt_in  = seq_len_ff;
                     pend_bad_in  = 1'b0;
                     search_start = 1'b1;
                  end
               end else begin
                  priority if (req_data_byte[7] == 1'b0) begin
                     seq_len_in   = 3'd1;
                     pend_cp_in   = CP_W'(req_data_byte);
                     pend_cnt_in  = 3'd1;
                     pend_bad_in  = 1'b0;
                     search_start = 1'b1;
                  end else if (req_data_byte[7:5] == 3'b110) begin
                     partial_in    = CP_W'(req_data_byte[4:0]);
                     bytes_left_in = 2'd1;
                     seq_len_in    = 3'd2;
                  end else if (req_data_byte[7:4] == 4'b1110) begin
                     partial_in    = CP_W'(req_data_byte[3:0]);
                     bytes_left_in = 2'd2;
                     seq_len_in    = 3'd3;
                  end else if (req_data_byte[7:3] == 5'b11110) begin
                     partial_in    = CP_W'(req_data_byte[2:0]);
                     bytes_left_in = 2'd3;
                     seq_len_in    = 3'd4;
                  end else begin
                     // A stray continuation or an over-long lead is reported
                     // at once and leaves the decode state idle.
                     pend_cp_in  = '0;
                     pend_cnt_in = 3'd1;
                     pend_bad_in = 1'b1;
                     state_in    = ST_EMIT;
                  end
               end
               if (search_start) begin
                  done_in  = 2'b00;
                  hit_in   = 2'b00;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (done_ff == 2'b11) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bytes_left_ff <= 2'd0;
         seq_len_ff    <= '0;
         partial_ff    <= '0;
         done_ff       <= 2'b00;
         hit_ff        <= 2'b00;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bytes_left_ff <= bytes_left_in;
         seq_len_ff    <= seq_len_in;
         partial_ff    <= partial_in;
         done_ff       <= done_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_cp_ff  <= pend_cp_in;
      pend_cnt_ff <= pend_cnt_in;
      pend_bad_ff <= pend_bad_in;
      if (rsp_load) begin
         rsp_cp_ff    <= pend_cp_ff;
         rsp_cnt_ff   <= pend_cnt_ff;
         rsp_start_ff <= hit_ff[0] && !pend_bad_ff;
         rsp_cont_ff  <= hit_ff[1] && !pend_bad_ff;
         rsp_bad_ff   <= pend_bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_cont_ff, rsp_start_ff, rsp_cnt_ff, rsp_cp_ff};
   assign rsp_tuser  = rsp_bad_ff;

endmodule

`default_nettype wire

FILE: rtl/u8icc_checker.sv
// Port-level checker for the classifier core and its bind statement.
`default_nettype none

module u8icc_checker
   import u8icc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // A bad lead reports codepoint zero, length one and no class.
   a_bad_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[25:0] == 26'h0200000)
      else $error("bad lead result fields wrong");

   // Every result carries a length from one to four.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] != 3'd0 && rsp_tdata[23:21] != 3'd5
                     && rsp_tdata[23:21] != 3'd6 && rsp_tdata[23:21] != 3'd7)
      else $error("result length out of range");

   // A table write never starts a search, so the block is ready right after it.
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == CMD_WRITE) |=> req_tready)
      else $error("request not ready after a table write");

   // Reset empties the result channel.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind utf8_identifier_char_classifier_core u8icc_checker u_u8icc_checker (.*);

`default_nettype wire

FILE: verif/u8icc_char_checker.sv
// Checker that predicts every result of the UTF-8 identifier classifier and compares it.
module u8icc_char_checker
   import u8icc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          mismatch_count,
   output int          chars_pending,
   output int          chars_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CP_W-1:0]    codepoint;
      logic [COUNT_W-1:0] byte_count;
      logic               is_start;
      logic               is_cont;
      logic               bad_lead;
   } char_class_type;

   char_class_type     expected_chars [$];
   logic [CP_W-1:0]    range_first_mem [2][TABLE_DEPTH];
   logic [CP_W-1:0]    range_last_mem  [2][TABLE_DEPTH];
   logic [CP_W-1:0]    cp_accum;
   logic [1:0]         cont_left;
   logic [COUNT_W-1:0] char_len;
   int                 errors = 0;
   int                 checked = 0;

   // Linear walk from entry 0; the end marker stops the walk without a hit.
   function automatic logic range_hit(input logic sel, input logic [CP_W-1:0] cp);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (range_first_mem[sel][i] == END_MARK) return 1'b0;
         if (range_first_mem[sel][i] <= cp && cp <= range_last_mem[sel][i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic char_class_type classify(input logic [CP_W-1:0] cp,
                                               input logic [COUNT_W-1:0] n);
      char_class_type c;
      c.codepoint  = cp;
      c.byte_count = n;
      c.is_start   = range_hit(SEL_START, cp);
      c.is_cont    = range_hit(SEL_CONTINUE, cp);
      c.bad_lead   = 1'b0;
      return c;
   endfunction

   task automatic predict_beat(input logic [1:0] user, input logic [63:0] data);
      logic [7:0]         b;
      logic [ENTRY_W-1:0] idx;
      char_class_type     bad;
      b   = data[7:0];
      idx = data[17:8];
      if (user[0] == CMD_WRITE) begin
         if (idx < TABLE_DEPTH) begin
            range_first_mem[user[1]][idx] = data[38:18];
            range_last_mem[user[1]][idx]  = data[59:39];
         end
      end else if (cont_left != 0) begin
         // Any byte is taken as a continuation here, whatever its top bits.
         cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 0) expected_chars.push_back(classify(cp_accum, char_len));
      end else if (!b[7]) begin
         char_len = 3'd1;
         expected_chars.push_back(classify(CP_W'(b), 3'd1));
      end else if (b[7:5] == 3'b110) begin
         cp_accum  = CP_W'(b[4:0]);
         cont_left = 2'd1;
         char_len  = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         cp_accum  = CP_W'(b[3:0]);
         cont_left = 2'd2;
         char_len  = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         cp_accum  = CP_W'(b[2:0]);
         cont_left = 2'd3;
         char_len  = 3'd4;
      end else begin
         bad            = '0;
         bad.byte_count = 3'd1;
         bad.bad_lead   = 1'b1;
         expected_chars.push_back(bad);
      end
   endtask

   task automatic check_result(input logic [31:0] data, input logic user);
      char_class_type want;
      if (expected_chars.size() == 0) begin
         $error("result beat with no character pending: tdata %h tuser %b", data, user);
         errors++;
      end else begin
         want = expected_chars.pop_front();
         checked++;
         if (data[20:0] !== want.codepoint) begin
            $error("codepoint: expected %h, got %h", want.codepoint, data[20:0]);
            errors++;
         end
         if (data[23:21] !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, data[23:21]);
            errors++;
         end
         if (data[24] !== want.is_start) begin
            $error("is_ident_start: expected %b, got %b", want.is_start, data[24]);
            errors++;
         end
         if (data[25] !== want.is_cont) begin
            $error("is_ident_continue: expected %b, got %b", want.is_cont, data[25]);
            errors++;
         end
         if (user !== want.bad_lead) begin
            $error("bad_lead: expected %b, got %b", want.bad_lead, user);
            errors++;
         end
      end
   endtask

   // A result always belongs to an earlier request, so results are checked first.
   always @(posedge clock) begin
      if (reset) begin
         cp_accum  = '0;
         cont_left = '0;
         char_len  = '0;
         expected_chars.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) predict_beat(req_tuser, req_tdata);
      end
      mismatch_count <= errors;
      chars_pending  <= expected_chars.size();
      chars_checked  <= checked;
   end

endmodule

FILE: verif/utf8_identifier_char_classifier_core_tb.sv
// Testbench top for the UTF-8 identifier classifier: clock, reset, stimulus and verdict.
module utf8_identifier_char_classifier_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import u8icc_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 5;
   // Longest quiet stretch of a correct run is one full table walk plus a
   // receiver stall; this is many times that.
   localparam int WATCHDOG_LIMIT = 20000;
   // Drain time after the last expected result: one worst-case search.
   localparam int DRAIN_CYCLES   = DEF_TABLE_DEPTH + 80;
   // Tables stay short in the random part so that searches stay short.
   localparam int MAX_LIVE       = 20;
   // Ranges in the long start table of the last phase, end marker excluded.
   localparam int LONG_LEN       = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   int mismatch_count;
   int chars_pending;
   int chars_checked;

   // Idle percentages of the sender and the receiver, changed per phase.
   int src_idle_pct  = 13;
   int sink_idle_pct = 77;

   int beats_sent  = 0;
   int writes_sent = 0;
   int quiet_cycles = 0;

   // Shadow of the two range tables. Entries 0..live_len-1 always hold real
   // ranges and entry live_len holds the end marker, so no search can ever
   // read an entry that was never written.
   logic [CP_W-1:0] shadow_first [2][DEF_TABLE_DEPTH];
   logic [CP_W-1:0] shadow_last  [2][DEF_TABLE_DEPTH];
   int              live_len     [2];

   always #(CLK_PERIOD / 2) clock = ~clock;

   utf8_identifier_char_classifier_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   u8icc_char_checker char_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending),
      .chars_checked  (chars_checked)
   );

   // The receiver decides its ready at every falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   // The watchdog ends a run in which no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one request beat at a falling edge, after a random idle gap, and
   // hold it until a rising edge sees tready. tvalid stays high afterwards;
   // the next beat or an idle gap replaces it at the following falling edge.
   task automatic send_beat(input logic cmd, input logic sel, input logic [63:0] data);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = {sel, cmd};
      req_tdata  = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // A table write; the data byte lane carries junk, which must be ignored.
   task automatic write_entry(input logic sel, input int idx,
                              input logic [CP_W-1:0] lo, input logic [CP_W-1:0] hi);
      send_beat(CMD_WRITE, sel, {4'b0, hi, lo, ENTRY_W'(idx), 8'($urandom)});
      shadow_first[sel][idx] = lo;
      shadow_last[sel][idx]  = hi;
      writes_sent++;
   endtask

   // A decode beat; the unused tdata lanes and the table select carry junk.
   task automatic send_byte(input logic [7:0] b);
      logic [51:0] junk;
      junk = 52'({$urandom, $urandom});
      send_beat(CMD_DECODE, 1'($urandom), {4'b0, junk, b});
   endtask

   // Range starts spread over every UTF-8 length band, and a few above the
   // Unicode ceiling but below the end marker.
   function automatic logic [CP_W-1:0] random_first();
      int band;
      band = $urandom_range(0, 9);
      if (band < 3) return CP_W'($urandom_range(0, 'h7F));
      else if (band < 5) return CP_W'($urandom_range('h80, 'h7FF));
      else if (band < 7) return CP_W'($urandom_range('h800, 'hFFFF));
      else if (band < 9) return CP_W'($urandom_range('h10000, 'h10FFFF));
      else return CP_W'($urandom_range('h110000, 'h11FFFE));
   endfunction

   // Mostly narrow ranges, some wide ones, and some with last below first.
   function automatic logic [CP_W-1:0] random_last(input logic [CP_W-1:0] lo);
      int pick;
      int hi;
      pick = $urandom_range(0, 9);
      if (pick == 0) return CP_W'($urandom_range(0, 'h10FFFF));
      hi = int'(lo) + ((pick < 7) ? $urandom_range(0, 15) : $urandom_range(0, 'hFFFF));
      if (hi > 'h10FFFF) hi = 'h10FFFF;
      return CP_W'(hi);
   endfunction

   // One random table update that keeps the shadow's invariant: grow the
   // table by one range and move the end marker up, cut it short with an end
   // marker in the middle, or overwrite a live range.
   task automatic random_table_write();
      logic            sel;
      int              k;
      logic [CP_W-1:0] lo;
      sel = 1'($urandom);
      lo  = random_first();
      if (live_len[sel] == 0 || (live_len[sel] < MAX_LIVE && $urandom_range(0, 2) == 0)) begin
         write_entry(sel, live_len[sel], lo, random_last(lo));
         write_entry(sel, live_len[sel] + 1, END_MARK, CP_W'($urandom_range(0, 'h10FFFF)));
         live_len[sel]++;
      end else if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(0, live_len[sel] - 1);
         write_entry(sel, k, END_MARK, CP_W'($urandom_range(0, 'h10FFFF)));
         live_len[sel] = k;
      end else begin
         k = $urandom_range(0, live_len[sel] - 1);
         write_entry(sel, k, lo, random_last(lo));
      end
   endtask

   // Encode a codepoint in len bytes. Garbled continuations get random top
   // bits, which the block takes as continuations anyway. Now and then a
   // table write lands in the middle of the sequence.
   task automatic send_char(input logic [CP_W-1:0] cp, input int len, input bit garble);
      logic [7:0] lead;
      logic [1:0] top;
      case (len)
         1:       lead = {1'b0, cp[6:0]};
         2:       lead = {3'b110, cp[10:6]};
         3:       lead = {4'b1110, cp[15:12]};
         default: lead = {5'b11110, cp[20:18]};
      endcase
      send_byte(lead);
      for (int i = len - 2; i >= 0; i--) begin
         if ($urandom_range(0, 19) == 0) random_table_write();
         top = garble ? 2'($urandom) : 2'b10;
         send_byte({top, cp[6*i +: 6]});
      end
   endtask

   // A well-formed character: often one at or just beside a live range edge,
   // otherwise a random value of a random length.
   task automatic send_random_char();
      logic            sel;
      int              j;
      int              len;
      logic [CP_W-1:0] lo;
      logic [CP_W-1:0] hi;
      logic [CP_W-1:0] cp;
      sel = 1'($urandom);
      if (live_len[sel] > 0 && $urandom_range(0, 9) < 4) begin
         j  = $urandom_range(0, live_len[sel] - 1);
         lo = shadow_first[sel][j];
         hi = shadow_last[sel][j];
         case ($urandom_range(0, 4))
            0:       cp = lo - 1'b1;
            1:       cp = lo;
            2:       cp = hi;
            3:       cp = hi + 1'b1;
            default: cp = lo + CP_W'($urandom_range(0, 15));
         endcase
         if (cp < 'h80) len = 1;
         else if (cp < 'h800) len = 2;
         else if (cp < 'h10000) len = 3;
         else len = 4;
      end else begin
         len = $urandom_range(1, 4);
         case (len)
            1:       cp = CP_W'($urandom_range(0, 'h7F));
            2:       cp = CP_W'($urandom_range(0, 'h7FF));
            3:       cp = CP_W'($urandom_range(0, 'hFFFF));
            default: cp = CP_W'($urandom);
         endcase
      end
      send_char(cp, len, ($urandom_range(0, 6) == 0));
   endtask

   // A lead byte followed by too few continuations; whatever comes next is
   // swallowed as the rest of the sequence.
   task automatic send_broken();
      int len;
      len = $urandom_range(2, 4);
      case (len)
         2:       send_byte({3'b110, 5'($urandom)});
         3:       send_byte({4'b1110, 4'($urandom)});
         default: send_byte({5'b11110, 3'($urandom)});
      endcase
      repeat ($urandom_range(0, len - 2)) send_byte({2'b10, 6'($urandom)});
   endtask

   // Mostly well-formed characters, with table writes, noise bytes and
   // broken sequences mixed in.
   task automatic run_random(input int count);
      int stop;
      int pick;
      stop = beats_sent + count;
      while (beats_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) random_table_write();
         else if (pick < 75) send_random_char();
         else if (pick < 90) send_byte(8'($urandom));
         else send_broken();
      end
   endtask

   initial begin
      live_len[SEL_START]    = 0;
      live_len[SEL_CONTINUE] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Phase one: sender idles rarely, receiver idles most of the time.
      src_idle_pct  = 13;
      sink_idle_pct = 77;

      // Directed part. Both tables get loaded, end marker included, before
      // the first character can start a search.
      write_entry(SEL_START, 0, 21'h41, 21'h5A);
      write_entry(SEL_START, 1, 21'h3B1, 21'h3C9);
      write_entry(SEL_START, 2, END_MARK, 21'h0);
      write_entry(SEL_CONTINUE, 0, 21'h30, 21'h39);
      write_entry(SEL_CONTINUE, 1, 21'h41, 21'h5A);
      write_entry(SEL_CONTINUE, 2, END_MARK, 21'h0);
      live_len[SEL_START]    = 2;
      live_len[SEL_CONTINUE] = 2;
      // Single-byte extremes and a letter found in both tables.
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h41);
      // Largest two- and three-byte values.
      send_byte(8'hDF);
      send_byte(8'hBF);
      send_byte(8'hEF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      // Largest four-byte lead: only its low three bits may reach the codepoint.
      send_byte(8'hF7);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      // Bad leads: a stray continuation byte, and the 11111xxx patterns.
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'hF8);
      // A table write in the middle of a two-byte sequence leaves it intact.
      send_byte(8'hCE);
      write_entry(SEL_CONTINUE, 1, 21'h3B1, 21'h3C9);
      send_byte(8'hB1);
      // An ASCII letter after a lead is taken as its continuation unchecked.
      send_byte(8'hC3);
      send_byte(8'h41);

      run_random(150);

      // Phase two: the idle ratios swap.
      src_idle_pct  = 77;
      sink_idle_pct = 13;
      run_random(150);

      // Phase three: no idling on either side.
      src_idle_pct  = 0;
      sink_idle_pct = 0;

      // Build a long start table so that a search walks far before it ends.
      // Only its last range covers the CJK block; every fourth range covers
      // four plane-16 values, and the rest are empty.
      for (int i = 0; i < LONG_LEN - 1; i++) begin
         if (i % 4 == 0) begin
            write_entry(SEL_START, i, 21'h100000 + CP_W'(i * 64),
                        21'h100003 + CP_W'(i * 64));
         end else begin
            write_entry(SEL_START, i, 21'h110000 + CP_W'(i), 21'h10FFFF);
         end
      end
      write_entry(SEL_START, LONG_LEN - 1, 21'h4E00, 21'h9FFF);
      write_entry(SEL_START, LONG_LEN, END_MARK, 21'h0);
      live_len[SEL_START] = LONG_LEN;
      repeat (6) send_char(21'h4E00 + CP_W'($urandom_range(0, 'h51FF)), 3, 1'b0);
      send_char(21'h41, 1, 1'b0);
      send_char(21'h7A, 1, 1'b0);
      send_char(21'h100201, 4, 1'b0);
      send_char(21'h10FFFF, 4, 1'b0);
      // Put an end marker back near the front so the random part stays fast.
      if (live_len[SEL_START] > 5) begin
         write_entry(SEL_START, 5, END_MARK, 21'h0);
         live_len[SEL_START] = 5;
      end

      run_random(25);

      // All stimulus is in; wait for every expected result, then for one
      // worst-case search so that a stray extra result would still show up.
      req_tvalid = 1'b0;
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats, %0d of them table writes, and %0d results.",
               beats_sent, writes_sent, chars_checked);
      $display("It included every bad lead form, a long start table walked to its end,",
               " writes in mid sequence, and three idle profiles.");
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (chars_pending != 0) $error("%0d expected results never arrived", chars_pending);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
